@@ rtl/core/ffbs_pkg.sv @@
// shared types, constants and helpers for the first-fit buffer suballocator
package ffbs_pkg;

  localparam int unsigned MaxBuffers = 16;
  localparam int unsigned IdxW       = (MaxBuffers > 1) ? $clog2(MaxBuffers) : 1;
  localparam int unsigned OpenW      = $clog2(MaxBuffers + 1);
  localparam int unsigned CountW     = 17;
  localparam int unsigned StartW     = 16;
  localparam int unsigned BufW       = 4;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [CountW-1:0]  CapLimit   = 17'h10000;
  localparam logic [CfgIdxW-1:0] CfgVertCap = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxCap  = 1'b1;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_GRANT   = 2'd1,
    ST_TOO_BIG = 2'd2,
    ST_NO_BUF  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_CHECK,
    PS_SCAN,
    PS_UPDATE,
    PS_OFFSET,
    PS_DONE
  } pool_state_e;

  typedef struct packed {
    status_e             status;
    logic [BufW-1:0]     buffer;
    logic [StartW-1:0]   start;
  } pool_res_t;

  typedef struct packed {
    logic idle;
    logic done;
  } pool_stat_t;

  // low four bits of a buffer number, zero-extended when the number is narrower
  function automatic logic [BufW-1:0] to_buf(input logic [OpenW-1:0] num);
    logic [OpenW+BufW-1:0] ext;
    ext = {{BufW{1'b0}}, num};
    return ext[BufW-1:0];
  endfunction

  // capacity register saturated at the buffer limit
  function automatic logic [CountW-1:0] sat_cap(input logic [CountW-1:0] reg_val);
    return reg_val[CountW-1] ? CapLimit : reg_val;
  endfunction

endpackage

@@ rtl/core/ffbs_pool.sv @@
// one pool: free-count store and first-fit scan sequencer over a shared subtractor
module ffbs_pool (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ffbs_pkg::CountW-1:0] count_i,
  input  logic [ffbs_pkg::CountW-1:0] cap_i,
  input  logic                       ack_i,
  output ffbs_pkg::pool_stat_t       stat_o,
  output ffbs_pkg::pool_res_t        res_o
);
  import ffbs_pkg::*;

  pool_state_e state_q, state_d;
  logic [OpenW-1:0]  idx_q, idx_d;
  logic [OpenW-1:0]  open_q, open_d;
  logic [OpenW-1:0]  pick_q, pick_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] cap_q, cap_d;
  logic [CountW-1:0] freec_q, freec_d;
  pool_res_t         res_q, res_d;

  logic [CountW-1:0] free_mem [MaxBuffers];
  logic              mem_we;
  logic [IdxW-1:0]   mem_addr;
  logic [CountW-1:0] mem_wdata;
  logic [CountW-1:0] slot_rd;

  // shared subtract unit
  logic [CountW-1:0] sub_a, sub_b;
  logic [CountW:0]   diff;
  logic              borrow;

  logic scan_end, pool_full, count_zero;

  assign slot_rd    = free_mem[idx_q[IdxW-1:0]];
  assign diff       = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow     = diff[CountW];
  assign scan_end   = (idx_q == open_q);
  assign pool_full  = (open_q == OpenW'(MaxBuffers));
  assign count_zero = (count_q == '0);

  always_comb begin
    unique case (state_q)
      PS_SCAN: begin
        sub_a = slot_rd;
        sub_b = count_q;
      end
      PS_UPDATE: begin
        sub_a = freec_q;
        sub_b = count_q;
      end
      PS_OFFSET: begin
        sub_a = cap_q;
        sub_b = freec_q;
      end
      default: begin
        sub_a = cap_q;
        sub_b = count_q;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      PS_IDLE:   if (start_i) state_d = PS_CHECK;
      PS_CHECK: begin
        if (count_zero || borrow) state_d = PS_DONE;
        else                      state_d = PS_SCAN;
      end
      PS_SCAN: begin
        if (scan_end) begin
          state_d = pool_full ? PS_DONE : PS_UPDATE;
        end else if (!borrow) begin
          state_d = PS_UPDATE;
        end
      end
      PS_UPDATE: state_d = PS_OFFSET;
      PS_OFFSET: state_d = PS_DONE;
      PS_DONE:   if (ack_i) state_d = PS_IDLE;
      default:   state_d = PS_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    idx_d     = idx_q;
    open_d    = open_q;
    pick_d    = pick_q;
    count_d   = count_q;
    cap_d     = cap_q;
    freec_d   = freec_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_addr  = pick_q[IdxW-1:0];
    mem_wdata = diff[CountW-1:0];
    unique case (state_q)
      PS_IDLE: begin
        if (start_i) begin
          count_d = count_i;
          cap_d   = cap_i;
          idx_d   = '0;
        end
      end
      PS_CHECK: begin
        if (count_zero) begin
          res_d = '{status: ST_NONE, buffer: '0, start: '0};
        end else if (borrow) begin
          res_d = '{status: ST_TOO_BIG, buffer: '0, start: '0};
        end
      end
      PS_SCAN: begin
        if (scan_end) begin
          if (pool_full) begin
            res_d = '{status: ST_NO_BUF, buffer: '0, start: '0};
          end else begin
            mem_we    = 1'b1;
            mem_addr  = open_q[IdxW-1:0];
            mem_wdata = cap_q;
            freec_d   = cap_q;
            pick_d    = open_q;
            open_d    = open_q + OpenW'(1);
          end
        end else if (!borrow) begin
          freec_d = slot_rd;
          pick_d  = idx_q;
        end else begin
          idx_d = idx_q + OpenW'(1);
        end
      end
      PS_UPDATE: begin
        mem_we = 1'b1;
      end
      PS_OFFSET: begin
        res_d.status = ST_GRANT;
        res_d.buffer = to_buf(pick_q);
        res_d.start  = borrow ? '0 : diff[StartW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PS_IDLE;
      open_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      open_q  <= open_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q  <= pick_d;
    count_q <= count_d;
    cap_q   <= cap_d;
    freec_q <= freec_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) free_mem[mem_addr] <= mem_wdata;
  end

  assign stat_o.idle = (state_q == PS_IDLE);
  assign stat_o.done = (state_q == PS_DONE);
  assign res_o       = res_q;

endmodule

@@ rtl/core/first_fit_buffer_suballocator_unit.sv @@
// top level: config registers, two pool sequencers and the result register
//
// Requests enter on the input channel (in_valid_i/in_ready_o) as one beat holding
// a vertex count and an index count; each beat gives exactly one result beat on
// the output channel (out_valid_o/out_ready_i) with status, buffer and start for
// both pools. A zero count reports "none asked" for that pool.
// The two pools run side by side, each stepping one subtractor through a fixed
// sequence: a capacity check, a first-fit scan of one open buffer per cycle, a
// free-count update and a start-offset step. A pool with a zero or oversized
// count goes from the check straight to done, and a pool with no buffer left
// ends after scanning every buffer; the result beat waits for the slower pool.
// in_ready_o is low until the result is loaded into the output register, so no new
// request is taken while one is in flight; with the receiver ready the next request
// is accepted in the cycle the result beat can leave; if the receiver stalls, a
// finished pool holds its result and the input stays closed until the output
// register frees up.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once; the
// user must make them while no request is in flight, the block does not enforce it.
// Reset closes every buffer in both pools and sets both capacities to 65536;
// no clearing pass is needed.
module first_fit_buffer_suballocator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffbs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ffbs_pkg::CountW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ffbs_pkg::CountW-1:0]   vertex_count_i,
  input  logic [ffbs_pkg::CountW-1:0]   index_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    vertex_status_o,
  output logic [ffbs_pkg::BufW-1:0]     vertex_buffer_o,
  output logic [ffbs_pkg::StartW-1:0]   vertex_start_o,
  output logic [1:0]                    index_status_o,
  output logic [ffbs_pkg::BufW-1:0]     index_buffer_o,
  output logic [ffbs_pkg::StartW-1:0]   index_start_o
);
  import ffbs_pkg::*;

  logic [CountW-1:0] vcap_q, vcap_d;
  logic [CountW-1:0] icap_q, icap_d;
  logic              out_valid_q, out_valid_d;
  pool_res_t         vout_q, iout_q;

  pool_stat_t v_stat, i_stat;
  pool_res_t  v_res, i_res;
  logic       start, load;

  always_comb begin
    vcap_d = vcap_q;
    icap_d = icap_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgVertCap: vcap_d = cfg_data_i;
        CfgIdxCap:  icap_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = v_stat.idle & i_stat.idle;
  assign start      = in_valid_i & in_ready_o;
  assign load       = v_stat.done & i_stat.done & (~out_valid_q | out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load)             out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  ffbs_pool u_vpool (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .count_i (vertex_count_i),
    .cap_i   (sat_cap(vcap_q)),
    .ack_i   (load),
    .stat_o  (v_stat),
    .res_o   (v_res)
  );

  ffbs_pool u_ipool (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .count_i (index_count_i),
    .cap_i   (sat_cap(icap_q)),
    .ack_i   (load),
    .stat_o  (i_stat),
    .res_o   (i_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcap_q      <= CapLimit;
      icap_q      <= CapLimit;
      out_valid_q <= 1'b0;
    end else begin
      vcap_q      <= vcap_d;
      icap_q      <= icap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      vout_q <= v_res;
      iout_q <= i_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign vertex_status_o = vout_q.status;
  assign vertex_buffer_o = vout_q.buffer;
  assign vertex_start_o  = vout_q.start;
  assign index_status_o  = iout_q.status;
  assign index_buffer_o  = iout_q.buffer;
  assign index_start_o   = iout_q.start;

endmodule
